// File: rtl/fsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants for the IPv4 fragment size planner
// Holds header/MTU constants, the shared ALU opcodes and the result item type.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam logic [15:0] HDR_BYTES = 16'd20;
  localparam logic [15:0] MTU_FLOOR = 16'd1044;
  localparam logic [15:0] MTU_RESET = 16'd1500;
  localparam logic [15:0] MF_BIT    = 16'h2000;
  localparam int          MAX_OUT   = 64;

  localparam int ALU_W = 24;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic             op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] byte_offset;
    logic [15:0] payload_length;
    logic [15:0] total_length;
    logic        more_fragments;
    logic [15:0] fragment_field;
    logic        last;
    logic        rejected;
  } res_t;

endpackage

// File: rtl/ipv4_fragment_size_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_fragment_size_planner: IPv4 fragmentation plan generator
// Top level: APB register for the link MTU, input and result channels,
// and the result holding register in front of the receiver.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, packet_length) takes one packet length
//   per item, 20-byte header included. in_ready is high only while the
//   sequencer is idle; one item is worked on at a time.
//   Result channel (out_valid/out_ready) gives one item per fragment in offset
//   order, last set on the final one. A length of 20 or less gives a single
//   item with rejected and last set.
//   Sequence: the first result follows two 16-step restoring divisions and a
//   6-step shift-add multiply on the shared adder, with a second multiply
//   pass when the middle size is bumped by 8. Each fragment then goes through
//   remaining length, select/load and offset advance, up to 64 pieces. A
//   short packet's item is loaded at the reject step, and the sequencer then
//   returns to idle to take the next packet.
//   Stalls: a result waits in the output register; while it is not taken the
//   sequencer holds at its select step. Once the last result is loaded, the
//   advance step idles it; the next packet can be taken while that result waits.
//   Reset (rst, synchronous) sets mtu to 1500, empties the output register
//   and returns the sequencer to idle. Write mtu only while idle.
// ----------------------------------------------------------------------------
module ipv4_fragment_size_planner (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] packet_length,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] byte_offset,
  output logic [15:0] payload_length,
  output logic [15:0] total_length,
  output logic        more_fragments,
  output logic [15:0] fragment_field,
  output logic        last,
  output logic        rejected
);
  import fsp_pkg::*;

  logic [15:0] mtu;
  logic        seq_idle;
  logic        res_free;
  logic        res_load;
  res_t        res;
  res_t        out_item;

  // MTU register: word 0; the upper word decodes to nothing
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, mtu};

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu <= MTU_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      mtu <= pwdata[15:0];
    end
  end

  assign in_ready = seq_idle;

  fsp_planner u_planner (
    .clk      (clk),
    .rst      (rst),
    .mtu      (mtu),
    .start    (in_valid && in_ready),
    .plen     (packet_length),
    .idle     (seq_idle),
    .res_free (res_free),
    .res_load (res_load),
    .res      (res)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item <= res;
    end
  end

  assign byte_offset    = out_item.byte_offset;
  assign payload_length = out_item.payload_length;
  assign total_length   = out_item.total_length;
  assign more_fragments = out_item.more_fragments;
  assign fragment_field = out_item.fragment_field;
  assign last           = out_item.last;
  assign rejected       = out_item.rejected;

endmodule

// File: rtl/fsp_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_alu: shared add/subtract unit
// One adder used by the sequencer for divide steps, shift-add multiply and
// the fragment offset walk.
// ----------------------------------------------------------------------------
module fsp_alu (
  input  fsp_pkg::alu_req_t              req,
  output logic [fsp_pkg::ALU_W-1:0]      result
);
  import fsp_pkg::*;

  always_comb begin
    case (req.op)
      ALU_SUB: result = req.a - req.b;
      default: result = req.a + req.b;
    endcase
  end

endmodule

// File: rtl/fsp_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_planner: fragmentation sequencer
// Runs two restoring divisions, a shift-add multiply and the fragment walk,
// all on the one shared ALU, and hands out one result item at a time.
// ----------------------------------------------------------------------------
module fsp_planner (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         mtu,
  input  logic                start,
  input  logic [15:0]         plen,
  output logic                idle,
  input  logic                res_free,
  output logic                res_load,
  output fsp_pkg::res_t       res
);
  import fsp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_REJ   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_FIRST = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_ADJ   = 4'd6;
  localparam logic [3:0] S_CALC  = 4'd7;
  localparam logic [3:0] S_SEL   = 4'd8;
  localparam logic [3:0] S_ADV   = 4'd9;

  logic [3:0]  state;
  logic [15:0] len;
  logic [15:0] mlim;      // effective mtu minus header
  logic [15:0] fmtu;
  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] dvs;
  logic [3:0]  cnt;
  logic        div2;
  logic [6:0]  nfrag;
  logic [16:0] mid;
  logic [5:0]  nm1;
  logic [22:0] mcand;
  logic [22:0] prod;
  logic [16:0] first;
  logic        pass2;
  logic [15:0] off;
  logic [15:0] left;
  logic [5:0]  k;
  logic [15:0] flen_r;
  logic        last_r;

  alu_req_t         areq;
  logic [ALU_W-1:0] ares;

  fsp_alu u_alu (
    .req    (areq),
    .result (ares)
  );

  // divide step helpers
  logic [16:0] shifted;
  logic        dbit;
  logic [15:0] rem_new;
  logic [15:0] quo_new;

  // fragment select helpers
  logic [16:0] pick;
  logic [15:0] flen;
  logic        more;
  logic        is_last;

  // setup helpers
  logic [15:0] m_eff;
  logic [15:0] mlim_in;

  assign m_eff   = (mtu < MTU_FLOOR) ? MTU_FLOOR : mtu;
  assign mlim_in = m_eff - HDR_BYTES;

  assign shifted = {rem, quo[15]};
  assign dbit    = ~ares[ALU_W-1];
  assign rem_new = dbit ? ares[15:0] : shifted[15:0];
  assign quo_new = {quo[14:0], dbit};

  always_comb begin
    areq.op = ALU_ADD;
    areq.a  = '0;
    areq.b  = '0;
    unique case (state)
      S_DIV: begin
        areq.op = ALU_SUB;
        areq.a  = {{(ALU_W-17){1'b0}}, shifted};
        areq.b  = {{(ALU_W-16){1'b0}}, dvs};
      end
      S_MUL: begin
        areq.a = {{(ALU_W-23){1'b0}}, prod};
        areq.b = {{(ALU_W-23){1'b0}}, mcand};
      end
      S_FIRST: begin
        areq.op = ALU_SUB;
        areq.a  = {{(ALU_W-17){1'b0}}, {1'b0, len} + 17'd7};
        areq.b  = {{(ALU_W-23){1'b0}}, prod};
      end
      S_ADJ: begin
        areq.a = {{(ALU_W-17){1'b0}}, mid};
        areq.b = {{(ALU_W-4){1'b0}}, 4'd8};
      end
      S_CALC: begin
        areq.op = ALU_SUB;
        areq.a  = {{(ALU_W-16){1'b0}}, len};
        areq.b  = {{(ALU_W-16){1'b0}}, off};
      end
      S_ADV: begin
        areq.a = {{(ALU_W-16){1'b0}}, off};
        areq.b = {{(ALU_W-16){1'b0}}, flen_r};
      end
      default: begin
        areq.op = ALU_ADD;
      end
    endcase
  end

  // Piece for this slot: whole tail if it fits, else first or middle size.
  always_comb begin
    if (left > mlim) begin
      pick = (off == 16'd0) ? first : mid;
    end else begin
      pick = {1'b0, left};
    end
    if (pick == 17'd0 || pick > {1'b0, left}) begin
      flen = left;
    end else begin
      flen = pick[15:0];
    end
    more    = flen < left;
    is_last = ~more || (k == 6'(MAX_OUT - 1));
  end

  always_comb begin
    res = '0;
    if (state == S_REJ) begin
      res.last     = 1'b1;
      res.rejected = 1'b1;
    end else begin
      res.byte_offset    = off;
      res.payload_length = flen;
      res.total_length   = flen + HDR_BYTES;
      res.more_fragments = more;
      res.fragment_field = {3'b000, off[15:3]} | (more ? MF_BIT : 16'h0000);
      res.last           = is_last;
      res.rejected       = 1'b0;
    end
  end

  assign idle     = (state == S_IDLE);
  assign res_load = res_free && (state == S_REJ || state == S_SEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (plen <= HDR_BYTES) begin
              state <= S_REJ;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_REJ: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (cnt == 4'd15) begin
            state <= div2 ? S_MUL : S_DIV;
          end
        end
        S_MUL: begin
          if (cnt == 4'd5) begin
            state <= S_FIRST;
          end
        end
        S_FIRST: state <= S_CHK;
        S_CHK: begin
          if (!pass2 && first > {1'b0, fmtu}) begin
            state <= S_ADJ;
          end else begin
            state <= S_CALC;
          end
        end
        S_ADJ:  state <= S_MUL;
        S_CALC: state <= S_SEL;
        S_SEL: begin
          if (res_free) begin
            state <= S_ADV;
          end
        end
        S_ADV:  state <= last_r ? S_IDLE : S_CALC;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        len   <= plen - HDR_BYTES;
        mlim  <= mlim_in;
        fmtu  <= {mlim_in[15:3], 3'b000};
        rem   <= '0;
        quo   <= plen - HDR_BYTES;
        dvs   <= {mlim_in[15:3], 3'b000};
        cnt   <= '0;
        div2  <= 1'b0;
        pass2 <= 1'b0;
      end
      S_DIV: begin
        rem <= rem_new;
        quo <= quo_new;
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          cnt <= '0;
          if (!div2) begin
            // fragment count, then divide the payload by it
            nfrag <= quo_new[6:0] + ((rem_new != 16'd0) ? 7'd1 : 7'd0);
            dvs   <= {9'd0, quo_new[6:0] + ((rem_new != 16'd0) ? 7'd1 : 7'd0)};
            rem   <= '0;
            quo   <= len;
            div2  <= 1'b1;
          end else begin
            mid   <= {1'b0, quo_new[15:3], 3'b000};
            mcand <= {7'd0, quo_new[15:3], 3'b000};
            nm1   <= 6'(nfrag - 7'd1);
            prod  <= '0;
          end
        end
      end
      S_MUL: begin
        if (nm1[0]) begin
          prod <= ares[22:0];
        end
        mcand <= {mcand[21:0], 1'b0};
        nm1   <= {1'b0, nm1[5:1]};
        cnt   <= (cnt == 4'd5) ? 4'd0 : cnt + 4'd1;
      end
      S_FIRST: begin
        // a negative difference wraps huge; hold it above any piece length
        if (ares[ALU_W-1]) begin
          first <= '1;
        end else begin
          first <= {ares[16:3], 3'b000};
        end
      end
      S_CHK: begin
        if (!pass2 && first > {1'b0, fmtu}) begin
          pass2 <= 1'b1;
        end else begin
          if (first < mid) begin
            first <= mid;
          end
          off <= '0;
          k   <= '0;
        end
      end
      S_ADJ: begin
        mid   <= ares[16:0];
        mcand <= {6'd0, ares[16:0]};
        nm1   <= 6'(nfrag - 7'd1);
        prod  <= '0;
        cnt   <= '0;
      end
      S_CALC: begin
        left <= ares[15:0];
      end
      S_SEL: begin
        flen_r <= flen;
        last_r <= is_last;
      end
      S_ADV: begin
        off <= ares[15:0];
        k   <= k + 6'd1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the IPv4 fragment size planner
// Feeds packet lengths under several link MTU settings, mirrors the
// fragmentation plan in a local predictor, and checks every fragment item
// field by field, in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import fsp_pkg::*;

  // Register map: mtu is the only register, at byte address 0.
  localparam logic [2:0] MTU_ADDR = 3'd0;

  // Cycles with no accepted item before the run is declared hung. The slowest
  // correct stretch is a drain, a register write and the plan setup behind
  // a sender gap, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 60;
  localparam int DIRECTED_ROWS  = 26;

  typedef enum logic [1:0] {
    ROW_MTU,           // drain, then write value to the mtu register
    ROW_PACKET,        // send value as a packet length, expect the predicted plan
    ROW_PACKET_TYPED   // send value, expect exactly the one fragment given
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] value;
    res_t        typed;
  } stim_row_t;

  localparam res_t SHORT_REJECT = '{16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b1};

  logic        clk;
  logic        rst           = 1'b1;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = MTU_ADDR;
  logic [31:0] pwdata        = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [15:0] packet_length = 16'd0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [15:0] byte_offset;
  logic [15:0] payload_length;
  logic [15:0] total_length;
  logic        more_fragments;
  logic [15:0] fragment_field;
  logic        last;
  logic        rejected;

  ipv4_fragment_size_planner i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .packet_length  (packet_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_offset    (byte_offset),
    .payload_length (payload_length),
    .total_length   (total_length),
    .more_fragments (more_fragments),
    .fragment_field (fragment_field),
    .last           (last),
    .rejected       (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Fragments still owed by the block, oldest first.
  res_t        frag_plan_q[$];
  logic [15:0] link_mtu = MTU_RESET;   // mirror of the mtu register
  int          fail_count = 0;
  int unsigned src_gap = 0;            // cycles to idle before the next item
  bit          src_quiet = 1'b0;       // sender sends back to back
  bit          sink_quiet = 1'b0;      // receiver never stalls
  int unsigned sink_wait = 0;
  int unsigned sink_draw;
  int unsigned idle_cycles = 0;

  // Plan the fragments of one packet under the current mtu and queue them.
  function automatic void plan_fragments(input logic [15:0] plen);
    int unsigned m, len, fmtu, nfrag, mid, first, off, left, flen;
    int          k;
    bit          more;
    res_t        piece;
    if (plen <= HDR_BYTES) begin
      frag_plan_q.push_back(SHORT_REJECT);
      return;
    end
    // Clamp a small mtu so a slot holds at least 1024 payload bytes.
    m     = (link_mtu < MTU_FLOOR) ? MTU_FLOOR : link_mtu;
    len   = plen - HDR_BYTES;
    fmtu  = (m - HDR_BYTES) & ~32'd7;
    nfrag = len / fmtu + ((len % fmtu != 0) ? 1 : 0);
    // Balance: equal middle pieces, first piece takes the rounding slack.
    mid   = (len / nfrag) & ~32'd7;
    first = (len - mid * (nfrag - 1) + 7) & ~32'd7;
    if (first > fmtu) begin
      mid  += 8;
      first = (len - mid * (nfrag - 1) + 7) & ~32'd7;
    end
    if (first < mid) first = mid;
    off = 0;
    k   = 0;
    while (off < len && k < MAX_OUT) begin
      left = len - off;
      flen = left;
      // A tail that fits the mtu goes out whole, even if not a multiple of 8.
      if (left > m - HDR_BYTES) flen = (off == 0) ? first : mid;
      if (flen == 0 || flen > left) flen = left;
      more = (off + flen) < len;
      piece.byte_offset    = 16'(off);
      piece.payload_length = 16'(flen);
      piece.total_length   = 16'(flen + HDR_BYTES);
      piece.more_fragments = more;
      piece.fragment_field = 16'((off >> 3) | (more ? MF_BIT : 16'd0));
      piece.last           = !more || (k == MAX_OUT - 1);
      piece.rejected       = 1'b0;
      frag_plan_q.push_back(piece);
      k++;
      off += flen;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Match the fragment on the result port against the oldest one owed.
  function automatic void check_fragment();
    res_t want;
    if (frag_plan_q.size() == 0) begin
      $error("fragment item with none expected: byte_offset %0d", byte_offset);
      fail_count++;
      return;
    end
    want = frag_plan_q.pop_front();
    compare_field("byte_offset",    want.byte_offset,    byte_offset);
    compare_field("payload_length", want.payload_length, payload_length);
    compare_field("total_length",   want.total_length,   total_length);
    compare_field("more_fragments", 16'(want.more_fragments), 16'(more_fragments));
    compare_field("fragment_field", want.fragment_field, fragment_field);
    compare_field("last",           16'(want.last),      16'(last));
    compare_field("rejected",       16'(want.rejected),  16'(rejected));
  endfunction

  // Receiver: check each accepted item, then may drop ready at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else if (out_valid && out_ready) begin
      check_fragment();
      sink_draw = sink_quiet ? 0 : $urandom_range(0, 6);
      out_ready <= (sink_draw == 0);
      sink_wait <= sink_draw;
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      if (sink_wait == 1) out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one packet length; on acceptance queue its plan. Valid stays high
  // only when the next item follows with no gap.
  task automatic send_packet(input logic [15:0] plen, input bit typed_ok,
                             input res_t typed_res);
    repeat (src_gap) @(posedge clk);
    in_valid      <= 1'b1;
    packet_length <= plen;
    do @(posedge clk); while (!in_ready);
    if (typed_ok) frag_plan_q.push_back(typed_res);
    else plan_fragments(plen);
    src_gap = src_quiet ? 0 : $urandom_range(0, 6);
    if (src_gap != 0) in_valid <= 1'b0;
  endtask

  // Hold the sender until every owed fragment has arrived and the block idles.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frag_plan_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_mtu(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MTU_ADDR;
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    link_mtu = value;
    @(posedge clk);
  endtask

  // Pick a packet length: mostly valid plans, some near slot boundaries,
  // some at the top of the range, a few short packets.
  function automatic logic [15:0] draw_length();
    int unsigned pick, m, fmtu, val;
    pick = $urandom_range(0, 99);
    m    = (link_mtu < MTU_FLOOR) ? MTU_FLOOR : link_mtu;
    fmtu = (m - HDR_BYTES) & ~32'd7;
    if (pick < 8) return 16'($urandom_range(0, 20));
    if (pick < 30) begin
      val = fmtu * $urandom_range(1, 4) + HDR_BYTES + $urandom_range(0, 16) - 8;
      return (val > 65535) ? 16'hFFFF : 16'(val);
    end
    if (pick < 40) return 16'(65535 - $urandom_range(0, 63));
    return 16'($urandom_range(21, 65535));
  endfunction

  // Directed table: short packets, single pieces, slot rounding, the mtu
  // floor, the widest mtu, and a full 64-fragment plan.
  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{ROW_PACKET_TYPED, 16'd0,     SHORT_REJECT},
    '{ROW_PACKET_TYPED, 16'd20,    SHORT_REJECT},
    '{ROW_PACKET_TYPED, 16'd21,    '{16'd0, 16'd1, 16'd21, 1'b0, 16'd0, 1'b1, 1'b0}},
    '{ROW_PACKET_TYPED, 16'd1500,  '{16'd0, 16'd1480, 16'd1500, 1'b0, 16'd0, 1'b1, 1'b0}},
    '{ROW_PACKET,       16'd1501,  SHORT_REJECT},
    '{ROW_PACKET,       16'd2981,  SHORT_REJECT},
    '{ROW_PACKET,       16'd65535, SHORT_REJECT},
    '{ROW_MTU,          16'd0,     SHORT_REJECT},
    '{ROW_PACKET,       16'd65535, SHORT_REJECT},
    '{ROW_PACKET,       16'd1045,  SHORT_REJECT},
    '{ROW_MTU,          16'd1043,  SHORT_REJECT},
    '{ROW_PACKET_TYPED, 16'd1044,  '{16'd0, 16'd1024, 16'd1044, 1'b0, 16'd0, 1'b1, 1'b0}},
    '{ROW_MTU,          16'd1044,  SHORT_REJECT},
    '{ROW_PACKET,       16'd65535, SHORT_REJECT},
    '{ROW_PACKET,       16'd1064,  SHORT_REJECT},
    '{ROW_MTU,          16'd1051,  SHORT_REJECT},
    '{ROW_PACKET_TYPED, 16'd1051,  '{16'd0, 16'd1031, 16'd1051, 1'b0, 16'd0, 1'b1, 1'b0}},
    '{ROW_PACKET,       16'd12345, SHORT_REJECT},
    '{ROW_MTU,          16'd65535, SHORT_REJECT},
    '{ROW_PACKET_TYPED, 16'd65535, '{16'd0, 16'd65515, 16'd65535, 1'b0, 16'd0, 1'b1, 1'b0}},
    '{ROW_PACKET_TYPED, 16'd19,    SHORT_REJECT},
    '{ROW_MTU,          16'd9000,  SHORT_REJECT},
    '{ROW_PACKET,       16'd40000, SHORT_REJECT},
    '{ROW_PACKET,       16'd65535, SHORT_REJECT},
    '{ROW_MTU,          16'd1500,  SHORT_REJECT},
    '{ROW_PACKET,       16'd4000,  SHORT_REJECT}
  };

  initial begin
    logic [15:0] phase_mtu;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: walk the table with random idling on both sides.
    foreach (directed_rows[r]) begin
      if (r % 8 == 0) begin
        src_quiet   = ($urandom_range(0, 2) == 0);
        sink_quiet <= ($urandom_range(0, 2) == 0);
      end
      if (directed_rows[r].kind == ROW_MTU) begin
        wait_drained();
        write_mtu(directed_rows[r].value);
      end else begin
        send_packet(directed_rows[r].value, directed_rows[r].kind == ROW_PACKET_TYPED,
                    directed_rows[r].typed);
      end
    end

    // Random part: one mtu setting per phase, extremes and saturation included.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: phase_mtu = MTU_RESET;
        1: phase_mtu = MTU_FLOOR;
        2: phase_mtu = 16'($urandom_range(0, 1043));
        3: phase_mtu = 16'hFFFF;
        4: phase_mtu = 16'($urandom_range(1044, 65535));
        5: phase_mtu = 16'($urandom_range(1044, 2000));
        default: phase_mtu = 16'($urandom);
      endcase
      wait_drained();
      write_mtu(phase_mtu);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Alternate stretches of back-to-back traffic with random idling.
        if (n % 20 == 0) begin
          src_quiet   = ($urandom_range(0, 3) == 0);
          sink_quiet <= ($urandom_range(0, 3) == 0);
        end
        // Hold the sender mid-phase until the block has gone fully idle.
        if (n == PHASE_ITEMS / 2) wait_drained();
        send_packet(draw_length(), 1'b0, SHORT_REJECT);
      end
    end

    // Let every owed fragment arrive; the watchdog bounds this wait.
    wait_drained();
    if (fail_count == 0 && frag_plan_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
